// ===== design/msem_pkg.sv =====
// shared types and constants for the multichannel semblance block
// no dependencies
package msem_pkg;

    localparam int MaxChannels     = 64;
    localparam int MaxHalfWidth    = 16;
    localparam int MaxTraceLength  = 4096;

    localparam int SampleW   = 16;
    localparam int CoherW    = 16;
    localparam int TidxW     = 12;
    localparam int ChanCfgW  = 7;
    localparam int HwCfgW    = 5;
    localparam int CfgIdxW   = 1;

    localparam logic [CfgIdxW-1:0] RegChannelCount = 1'b0;
    localparam logic [CfgIdxW-1:0] RegHalfWidth    = 1'b1;

    localparam int CfgDataW  = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CLOSE,
        ST_SUM,
        ST_DIV,
        ST_OUT,
        ST_FLUSH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accum;      // add accepted sample into column
        logic close;      // shift column into window, clear column
        logic shift_zero; // shift a zero column in
        logic sum_start;  // clear window sums, start walk
        logic sum_step;   // one window tap
        logic div_start;
        logic div_step;
        logic out_load;   // load output register
        logic clear;      // back to reset state after trace end
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic col_full;
        logic emit_ok;
        logic sum_done;
        logic div_done;
        logic tail_left;
    } sts_t;

endpackage

// ===== design/msem_datapath.sv =====
// datapath: column accumulation, window column memory, weighted sum walk and divider
// depends on msem_pkg
module msem_datapath #(
    parameter int MAX_CHANNELS     = msem_pkg::MaxChannels,
    parameter int MAX_HALF_WIDTH   = msem_pkg::MaxHalfWidth,
    parameter int MAX_TRACE_LENGTH = msem_pkg::MaxTraceLength
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  msem_pkg::cmd_t                cmd,
    output msem_pkg::sts_t                sts,
    input  logic [msem_pkg::ChanCfgW-1:0] channel_count,
    input  logic [msem_pkg::HwCfgW-1:0]   half_width,
    input  logic [msem_pkg::SampleW-1:0]  sample,
    input  logic                          end_flag,
    output logic [msem_pkg::CoherW-1:0]   coherence,
    output logic [msem_pkg::TidxW-1:0]    time_index
);
    import msem_pkg::*;

    localparam int WinLen = 2 * MAX_HALF_WIDTH + 1;
    localparam int AddrW  = $clog2(WinLen + 1);
    localparam int PosW   = $clog2(WinLen + 2);
    localparam int HwW    = $clog2(MAX_HALF_WIDTH + 2);
    localparam int ChW    = $clog2(MAX_CHANNELS + 1);
    localparam int CsW    = SampleW + $clog2(MAX_CHANNELS + 1);
    localparam int GW     = 2 * CsW;
    localparam int EW     = 2 * SampleW + $clog2(MAX_CHANNELS + 1);
    localparam int WtW    = HwW;
    localparam int SW     = GW + 2 * HwW + 1;
    localparam int XW     = EW + 2 * HwW + 1;
    localparam int DW     = XW + ChW;
    localparam int CntW   = 32;
    localparam int TiW    = $clog2(MAX_TRACE_LENGTH);

    // effective configuration
    logic [ChW-1:0] eff_ch;
    logic [HwW-1:0] eff_hw;
    always_comb begin
        if (channel_count == '0) begin
            eff_ch = ChW'(1);
        end else if (32'(channel_count) > 32'(MAX_CHANNELS)) begin
            eff_ch = ChW'(MAX_CHANNELS);
        end else begin
            eff_ch = ChW'(channel_count);
        end
        if (32'(half_width) > 32'(MAX_HALF_WIDTH)) begin
            eff_hw = HwW'(MAX_HALF_WIDTH);
        end else begin
            eff_hw = HwW'(half_width);
        end
    end

    // column accumulation
    logic signed [CsW-1:0] csum_reg;
    logic [EW-1:0]         csq_reg;
    logic [ChW-1:0]        ccnt_reg;
    logic signed [SampleW-1:0] s;
    logic [SampleW-1:0]    smag;
    assign s    = sample;
    assign smag = s[SampleW-1] ? SampleW'(-s) : SampleW'(s);

    logic [CsW-1:0] cmag;
    assign cmag = csum_reg[CsW-1] ? CsW'(-csum_reg) : CsW'(csum_reg);

    // window columns live in a circular memory; tail zero columns are not written
    logic [GW-1:0] mem_g [WinLen];
    logic [EW-1:0] mem_e [WinLen];
    logic [AddrW-1:0] wp_reg;
    logic [CntW-1:0] seen_reg;
    logic [CntW-1:0] seen_inc;
    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
    logic [HwW-1:0] tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            csum_reg <= '0;
            csq_reg  <= '0;
            ccnt_reg <= '0;
            seen_reg <= '0;
            tail_reg <= '0;
            wp_reg   <= '0;
        end else begin
            if (cmd.accum) begin
                csum_reg <= csum_reg + CsW'(s);
                csq_reg  <= csq_reg + EW'(smag * smag);
                ccnt_reg <= ccnt_reg + 1'b1;
            end
            if (cmd.close) begin
                csum_reg <= '0;
                csq_reg  <= '0;
                ccnt_reg <= '0;
                seen_reg <= seen_inc;
                tail_reg <= '0;
                wp_reg   <= (wp_reg == AddrW'(WinLen - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (cmd.shift_zero) begin
                tail_reg <= tail_reg + 1'b1;
            end
        end
    end

    // column closes on count or trace end
    assign sts.col_full = (ccnt_reg + 1'b1 >= eff_ch) || end_flag;
    assign sts.tail_left = tail_reg < eff_hw;
    // index of the result about to be formed; tail counts extra zero columns
    logic [CntW-1:0] pos_seen;
    assign pos_seen = seen_reg - 1'b1 + CntW'(tail_reg);
    assign sts.emit_ok = (tail_reg == '0) ? (seen_reg > CntW'(eff_hw))
                                          : (pos_seen >= CntW'(eff_hw));
    logic [CntW-1:0] idx;
    assign idx = pos_seen - CntW'(eff_hw);

    // weighted window walk, one tap a cycle, each memory read registered in the cycle before its tap is added
    logic [PosW-1:0]  pos_reg;
    logic [SW-1:0]    ss_reg;
    logic [XW-1:0]    sx_reg;
    logic [PosW-1:0]  tap_dist;
    logic [WtW-1:0]   wt;
    logic             tap_issue;
    logic             tap_live;
    logic [PosW-1:0]  age;
    logic [AddrW:0]   rd_sum;
    logic [AddrW-1:0] rd_addr;
    logic [GW-1:0]    tap_g_reg;
    logic [EW-1:0]    tap_e_reg;
    logic [WtW-1:0]   wt_reg;
    logic             rd_vld_reg;

    always_comb begin
        if (pos_reg > PosW'(eff_hw)) tap_dist = pos_reg - PosW'(eff_hw);
        else tap_dist = PosW'(eff_hw) - pos_reg;
        wt = eff_hw + 1'b1 - HwW'(tap_dist);
        tap_issue = (32'(pos_reg) <= 2 * 32'(eff_hw));
        // positions below the tail count are zero columns, beyond seen are before the trace
        if (tap_issue && (pos_reg >= PosW'(tail_reg))) age = pos_reg - PosW'(tail_reg);
        else age = '0;
        tap_live = tap_issue && (pos_reg >= PosW'(tail_reg)) && (CntW'(age) < seen_reg);
        rd_sum = (AddrW+1)'(wp_reg) + (AddrW+1)'(WinLen - 1) - (AddrW+1)'(age);
        if (rd_sum >= (AddrW+1)'(WinLen)) rd_addr = AddrW'(rd_sum - (AddrW+1)'(WinLen));
        else rd_addr = AddrW'(rd_sum);
    end

    always_ff @(posedge aclk) begin
        if (cmd.close) begin
            mem_g[wp_reg] <= GW'(cmag * cmag);
            mem_e[wp_reg] <= csq_reg;
        end
        if (cmd.sum_step) begin
            tap_g_reg <= mem_g[rd_addr];
            tap_e_reg <= mem_e[rd_addr];
        end
    end

    assign sts.sum_done = (32'(pos_reg) > 2 * 32'(eff_hw) + 1);

    always_ff @(posedge aclk) begin
        if (cmd.sum_start) begin
            pos_reg    <= '0;
            ss_reg     <= '0;
            sx_reg     <= '0;
            rd_vld_reg <= 1'b0;
        end else if (cmd.sum_step) begin
            pos_reg    <= pos_reg + 1'b1;
            rd_vld_reg <= tap_live;
            wt_reg     <= wt;
            if (rd_vld_reg) begin
                ss_reg <= ss_reg + SW'(tap_g_reg * wt_reg);
                sx_reg <= sx_reg + XW'(tap_e_reg * wt_reg);
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [DW-1:0]  den_reg;
    logic [DW:0]    rem_reg;
    logic [CoherW-1:0] q_reg;
    logic [4:0]     dcnt_reg;
    logic           zero_reg, sat_reg;
    logic [DW:0]    rem_sh;
    assign rem_sh = {rem_reg[DW-1:0], 1'b0};
    logic [DW-1:0]  den_full;
    assign den_full = DW'(sx_reg) * DW'(eff_ch);
    assign sts.div_done = (dcnt_reg == 5'd16);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            den_reg  <= den_full;
            rem_reg  <= (DW+1)'(ss_reg);
            q_reg    <= '0;
            dcnt_reg <= '0;
            zero_reg <= (den_full == '0);
            sat_reg  <= ((DW+1)'(ss_reg) >= (DW+1)'(den_full));
        end else if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 1'b1;
            if (rem_sh >= (DW+1)'(den_reg)) begin
                rem_reg <= rem_sh - (DW+1)'(den_reg);
                q_reg   <= {q_reg[CoherW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[CoherW-2:0], 1'b0};
            end
        end
    end

    logic [TiW-1:0] idx_reg;
    always_ff @(posedge aclk) begin
        if (cmd.sum_start) idx_reg <= idx[TiW-1:0];
        if (cmd.out_load) begin
            if (zero_reg) coherence <= '0;
            else if (sat_reg) coherence <= '1;
            else coherence <= q_reg;
            time_index <= TidxW'(idx_reg);
        end
    end
endmodule

// ===== design/msem_ctrl.sv =====
// controller state machine: sequences column close, window walk, divide and tail flush
// depends on msem_pkg
module msem_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           trace_end,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_last,
    output msem_pkg::cmd_t cmd,
    input  msem_pkg::sts_t sts
);
    import msem_pkg::*;

    state_t state_reg, state_next;
    logic   end_reg, end_next;
    logic   mv_reg, mv_next;
    logic   ml_reg, ml_next;
    logic   out_free;
    assign out_free = !mv_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            end_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            ml_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            end_reg   <= end_next;
            mv_reg    <= mv_next;
            ml_reg    <= ml_next;
        end
    end

    assign m_valid = mv_reg;
    assign m_last  = ml_reg;

    always_comb begin
        state_next = state_reg;
        end_next   = end_reg;
        mv_next    = mv_reg && !m_ready;
        ml_next    = ml_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE, ST_ACC: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accum = 1'b1;
                    if (sts.col_full) begin
                        end_next   = trace_end;
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                cmd.close  = 1'b1;
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                // decide whether the current window position yields an item
                if (sts.emit_ok) begin
                    cmd.sum_start = 1'b1;
                    state_next    = ST_SUM;
                end else if (end_reg && sts.tail_left) begin
                    cmd.shift_zero = 1'b1;
                end else if (end_reg) begin
                    cmd.clear  = 1'b1;
                    end_next   = 1'b0;
                    state_next = ST_ACC;
                end else begin
                    state_next = ST_ACC;
                end
            end
            ST_SUM: begin
                // the last tap is in the sums once sum_done rises
                if (sts.sum_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.sum_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (!sts.div_done) begin
                    cmd.div_step = 1'b1;
                end else if (out_free) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    ml_next      = end_reg && !sts.tail_left;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (end_reg && sts.tail_left) begin
                    cmd.shift_zero = 1'b1;
                    state_next     = ST_FLUSH;
                end else if (end_reg) begin
                    cmd.clear  = 1'b1;
                    end_next   = 1'b0;
                    state_next = ST_ACC;
                end else begin
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end
endmodule

// ===== design/multichannel_semblance.sv =====
// top level of the multichannel semblance block
// depends on msem_pkg, msem_ctrl, msem_datapath
//
// Samples arrive column by column. A column that yields no result passes
// through close and the flush decision before the next sample is taken; one
// that yields a result also runs the window walk (one tap a cycle, plus a
// step for the registered memory read and one to start the divider), the
// 16-step restoring divider and the output load. At trace end zero columns
// are shifted in, and each tail result runs the flush decision, walk, divider
// and output load again. One output register holds a result until it is
// taken; while it is full a finished divide waits, and no sample is accepted
// during that wait.
module multichannel_semblance #(
    parameter int MAX_CHANNELS     = msem_pkg::MaxChannels,
    parameter int MAX_HALF_WIDTH   = msem_pkg::MaxHalfWidth,
    parameter int MAX_TRACE_LENGTH = msem_pkg::MaxTraceLength
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [msem_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [msem_pkg::CfgDataW-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [msem_pkg::SampleW-1:0]  s_sample,
    input  logic                          s_trace_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [msem_pkg::CoherW-1:0]   m_coherence,
    output logic [msem_pkg::TidxW-1:0]    m_time_index,
    output logic                          m_last
);
    import msem_pkg::*;

    logic [ChanCfgW-1:0] chan_reg;
    logic [HwCfgW-1:0]   hw_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_reg <= ChanCfgW'(16);
            hw_reg   <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                RegChannelCount: chan_reg <= cfg_data[ChanCfgW-1:0];
                RegHalfWidth:    hw_reg   <= cfg_data[HwCfgW-1:0];
                default: ;
            endcase
        end
    end

    msem_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .trace_end (s_trace_end),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_last    (m_last),
        .cmd       (cmd),
        .sts       (sts)
    );

    msem_datapath #(
        .MAX_CHANNELS     (MAX_CHANNELS),
        .MAX_HALF_WIDTH   (MAX_HALF_WIDTH),
        .MAX_TRACE_LENGTH (MAX_TRACE_LENGTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .channel_count (chan_reg),
        .half_width    (hw_reg),
        .sample        (s_sample),
        .end_flag      (s_trace_end),
        .coherence     (m_coherence),
        .time_index    (m_time_index)
    );
endmodule
